@@ sv/gwp_pkg.sv @@
// Package for the GPS word parity encoder.
// Holds request types, parity masks and byte framing constants.
// No dependencies.
package gwp_pkg;

    localparam int WORD_BITS   = 30;
    localparam int DATA_BITS   = 24;
    localparam int PAR_BITS    = 6;
    localparam int BYTE_CNT_W  = 3;

    localparam logic [BYTE_CNT_W-1:0] FIRST_BYTE = 3'd0;
    localparam logic [BYTE_CNT_W-1:0] LAST_BYTE  = 3'd4;

    localparam logic [1:0] FRAME_MARK = 2'b01;

    localparam logic [WORD_BITS-1:0] PAR_MASK [PAR_BITS] = '{
        30'h3b1f3480, 30'h1d8f9a40, 30'h2ec7cd00,
        30'h1763e680, 30'h2bb1f340, 30'h0b7a89c0
    };

    // bit k set: the k-th parity bit (D25 first) chains from D30*, else from D29*
    localparam logic [PAR_BITS-1:0] PAR_USES_D30 = 6'b011010;

    typedef struct packed {
        logic [DATA_BITS-1:0] data_word;
        logic                 last_word;
    } in_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       word_done;
        logic       message_end;
    } out_req_t;

    typedef struct packed {
        logic d29;
        logic d30;
    } chain_t;

    function automatic logic [5:0] reverse6(input logic [5:0] s);
        logic [5:0] r;
        for (int k = 0; k < 6; k++)
        begin
            r[5-k] = s[k];
        end
        return r;
    endfunction

endpackage

@@ sv/gps_word_parity_encoder.sv @@
// GPS word parity encoder top level: parity, chaining and 6-of-8 byte output.
// Depends on gwp_pkg and gwp_parity.
// First byte is valid in the cycle after the input request is taken.
// Each word leaves as five output bytes, and the next word is taken in the cycle
// its predecessor's fifth byte leaves; out_stall holds the flow.
// Reset: output empty, chained D29*/D30* set to 1.
module gps_word_parity_encoder
    import gwp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_req_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output out_req_t out_data
);

    logic [WORD_BITS-1:0]  word_reg;
    logic                  last_reg;
    logic [BYTE_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    chain_t                chain_reg;

    logic [WORD_BITS-1:0]  word_next;
    chain_t                chain_next;
    logic                  in_take;
    logic                  out_take;
    logic                  last_out;
    logic [5:0]            sextet;

    gwp_parity u_parity (
        .data (in_data.data_word),
        .prev (chain_reg),
        .word (word_next),
        .next (chain_next)
    );

    assign out_take = busy_reg && !out_stall;
    assign last_out = out_take && (cnt_reg == LAST_BYTE);
    assign in_stall = busy_reg && !last_out;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= FIRST_BYTE;
            chain_reg.d29 <= 1'b1;
            chain_reg.d30 <= 1'b1;
        end
        else
        begin
            if (in_take)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= FIRST_BYTE;
                chain_reg <= chain_next;
            end
            else if (last_out)
            begin
                busy_reg <= 1'b0;
                cnt_reg  <= FIRST_BYTE;
            end
            else if (out_take)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            word_reg <= word_next;
            last_reg <= in_data.last_word;
        end
    end

    always_comb
    begin
        case (cnt_reg)
            3'd0:    sextet = word_reg[29:24];
            3'd1:    sextet = word_reg[23:18];
            3'd2:    sextet = word_reg[17:12];
            3'd3:    sextet = word_reg[11:6];
            3'd4:    sextet = word_reg[5:0];
            default: sextet = 6'd0;
        endcase
    end

    assign out_valid            = busy_reg;
    assign out_data.out_byte    = {FRAME_MARK, reverse6(sextet)};
    assign out_data.word_done   = (cnt_reg == LAST_BYTE);
    assign out_data.message_end = (cnt_reg == LAST_BYTE) && last_reg;

    a_take_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> (!busy_reg || last_out))
        else $error("input request taken while output word pending");

    a_take_starts_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (busy_reg && cnt_reg == FIRST_BYTE))
        else $error("new word does not start at first byte");

    a_drain_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (last_out && !in_take) |=> !busy_reg)
        else $error("block busy after last byte left");

    a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_take |=> $stable(chain_reg))
        else $error("parity chain changed without input request");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= LAST_BYTE))
        else $error("byte counter out of range");

endmodule

@@ sv/gwp_parity.sv @@
// Parity generator: builds the 30-bit transmitted word from 24 data bits
// and the chained D29*/D30* bits. Depends on gwp_pkg.
module gwp_parity
    import gwp_pkg::*;
(
    input  logic [DATA_BITS-1:0] data,
    input  chain_t               prev,
    output logic [WORD_BITS-1:0] word,
    output chain_t               next
);

    logic [WORD_BITS-1:0] frame;
    logic [PAR_BITS-1:0]  parity;
    logic [DATA_BITS-1:0] tx_data;

    assign frame = {data, {PAR_BITS{1'b0}}};

    always_comb
    begin
        for (int k = 0; k < PAR_BITS; k++)
        begin
            parity[PAR_BITS-1-k] = (^(frame & PAR_MASK[k]))
                                   ^ (PAR_USES_D30[k] ? prev.d30 : prev.d29);
        end
    end

    // invert data when D30* is set
    assign tx_data  = prev.d30 ? ~data : data;
    assign word     = {tx_data, parity};
    assign next.d29 = parity[1];
    assign next.d30 = parity[0];

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Testbench for gps_word_parity_encoder: directed table, then random words checked byte by byte.
// Uses its own parity and chaining predictor. Depends on gwp_pkg and the encoder RTL.
module tb
    import gwp_pkg::*;
();

    typedef struct packed {
        logic [23:0] data;
        logic        last;
        logic        typed;
        logic [39:0] bytes;
    } dir_row_t;

    localparam int NDIR = 19;
    localparam int NRAND = 260;

    localparam dir_row_t DIR_ROWS [NDIR] = '{
        '{24'h000000, 1'b0, 1'b1, 40'h7f7f7f7f7f},
        '{24'h000000, 1'b1, 1'b1, 40'h7f7f7f7f7f},
        '{24'hffffff, 1'b0, 1'b0, 40'h0},
        '{24'h000000, 1'b0, 1'b0, 40'h0},
        '{24'h800000, 1'b0, 1'b0, 40'h0},
        '{24'h000001, 1'b0, 1'b0, 40'h0},
        '{24'haaaaaa, 1'b0, 1'b0, 40'h0},
        '{24'h555555, 1'b1, 1'b0, 40'h0},
        '{24'hffffff, 1'b0, 1'b0, 40'h0},
        '{24'hffffff, 1'b0, 1'b0, 40'h0},
        '{24'h000000, 1'b1, 1'b0, 40'h0},
        '{24'h0f0f0f, 1'b0, 1'b0, 40'h0},
        '{24'hf0f0f0, 1'b0, 1'b0, 40'h0},
        '{24'h123456, 1'b0, 1'b0, 40'h0},
        '{24'hfedcba, 1'b1, 1'b0, 40'h0},
        '{24'h400000, 1'b0, 1'b0, 40'h0},
        '{24'h000002, 1'b0, 1'b0, 40'h0},
        '{24'h7fffff, 1'b0, 1'b0, 40'h0},
        '{24'hfffffe, 1'b1, 1'b0, 40'h0}
    };

    localparam logic [29:0] PARITY_MASK [6] = '{
        30'h3b1f3480, 30'h1d8f9a40, 30'h2ec7cd00,
        30'h1763e680, 30'h2bb1f340, 30'h0b7a89c0
    };
    localparam logic [5:0] CHAIN_FROM_D30 = 6'b011010;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    in_req_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    out_req_t out_data;

    logic     chain_d29 = 1'b1;
    logic     chain_d30 = 1'b1;
    out_req_t expected_bytes [$];

    int  errors = 0;
    int  words_sent = 0;
    int  messages_sent = 0;
    int  bytes_checked = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    bit  rx_hold = 1'b0;
    int  rx_wait = 0;

    gps_word_parity_encoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

    task automatic report(input string msg);
        errors++;
        if (errors <= 40)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    function automatic logic [39:0] encode_word(input logic [23:0] d);
        logic [29:0] frame;
        logic [29:0] word;
        logic [23:0] tx;
        logic [5:0]  par;
        logic [5:0]  sext;
        logic [39:0] bytes;
        frame = {d, 6'b0};
        par = '0;
        for (int k = 0; k < 6; k++)
        begin
            par = {par[4:0],
                   (^(frame & PARITY_MASK[k])) ^ (CHAIN_FROM_D30[k] ? chain_d30 : chain_d29)};
        end
        tx = chain_d30 ? ~d : d;
        word = {tx, par};
        chain_d29 = par[1];
        chain_d30 = par[0];
        for (int k = 0; k < 5; k++)
        begin
            sext = word[29-6*k -: 6];
            bytes[39-8*k -: 8] = {2'b01, sext[0], sext[1], sext[2], sext[3], sext[4], sext[5]};
        end
        return bytes;
    endfunction

    task automatic send_request(input logic [23:0] d, input logic last, input logic typed,
                                input logic [39:0] typed_bytes);
        int        gap;
        in_req_t   req;
        logic [39:0] bytes;
        out_req_t  o;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        req.data_word = d;
        req.last_word = last;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (in_stall);
        bytes = encode_word(d);
        if (typed)
        begin
            bytes = typed_bytes;
        end
        for (int k = 0; k < 5; k++)
        begin
            o.out_byte = bytes[39-8*k -: 8];
            o.word_done = (k == 4);
            o.message_end = (k == 4) && last;
            expected_bytes.push_back(o);
        end
        words_sent++;
        if (last)
        begin
            messages_sent++;
        end
    endtask

    always @(posedge clk)
    begin
        out_req_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                bytes_checked++;
                if (expected_bytes.size() == 0)
                begin
                    report($sformatf("unexpected byte %02h", out_data.out_byte));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                        report($sformatf("out_byte %02h, want %02h",
                                         out_data.out_byte, want.out_byte));
                    if (out_data.word_done !== want.word_done)
                        report($sformatf("word_done %b, want %b",
                                         out_data.word_done, want.word_done));
                    if (out_data.message_end !== want.message_end)
                        report($sformatf("message_end %b, want %b",
                                         out_data.message_end, want.message_end));
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 5);
            end
            if (rx_hold || rx_wait > 0)
            begin
                out_stall <= 1'b1;
                if (rx_wait > 0)
                begin
                    rx_wait--;
                end
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        wait (words_sent >= 80);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (80) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        logic [23:0] d;
        int          pick;
        int          drain;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NDIR; i++)
        begin
            send_request(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].typed,
                         DIR_ROWS[i].bytes);
        end

        for (int i = 0; i < NRAND; i++)
        begin
            tx_quiet = ((i / 30) % 3 == 1);
            rx_quiet <= ((i / 30) % 4 == 2);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                d = 24'h000000;
            else if (pick == 1)
                d = 24'hffffff;
            else if (pick == 2)
                d = 24'h1 << $urandom_range(0, 23);
            else
                d = 24'($urandom);
            send_request(d, ($urandom_range(0, 7) == 0), 1'b0, 40'h0);
        end
        in_valid <= 1'b0;

        drain = 0;
        while (expected_bytes.size() != 0 && drain < 3000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (expected_bytes.size() != 0)
        begin
            report($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
        end

        $display("Sent %0d words in %0d marked messages, compared %0d output bytes,",
                 words_sent, messages_sent, bytes_checked);
        $display("with random gaps, back-to-back stretches and one long output hold.");
        if (errors == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
